[sv/lla_pkg.sv]
// Shared types and constants for the life-like automaton grid.
// No dependencies; lla_window, the top level and the testbench import this package.
`default_nettype none

package lla_pkg;

  // Fixed field widths of the item and result words
  localparam int unsigned OP_W       = 2;
  localparam int unsigned COORD_W    = 6;
  localparam int unsigned COORD_SPAN = 64;
  localparam int unsigned MASK_W     = 9;
  localparam int unsigned NCNT_W     = 4;
  localparam int unsigned LIVE_OUT_W = 13;
  localparam int unsigned GEN_W      = 32;

  // Configuration port
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned REG_SEL    = 2;   // paddr bit that picks the register
  localparam logic        REG_BIRTH   = 1'b0;
  localparam logic        REG_SURVIVE = 1'b1;

  localparam logic [MASK_W-1:0] BIRTH_RESET   = 9'd8;
  localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'd12;

  // Operation codes; the unused code acts as a read
  localparam logic [OP_W-1:0] OP_TOGGLE = 2'd0;
  localparam logic [OP_W-1:0] OP_STEP   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_MOD,
    ST_PRIME,
    ST_SWEEP,
    ST_DONE
  } state_e;

  // Controls from the sequencer to the neighborhood window
  typedef struct packed {
    logic prime_shift;  // shift a freshly read row into the bottom of the window
    logic pre_load;     // capture the prefetched row
    logic cell_adv;     // rotate rows by one column
    logic row_end;      // move the window down one row
  } win_ctl_t;

endpackage

`default_nettype wire

[sv/lla_row_mem.sv]
// Row-wide cell memory: one grid row per word, two banks for ping-pong steps.
// One write and one registered read per cycle. Self-contained, no package imports.
`default_nettype none

module lla_row_mem #(
  parameter int unsigned GRID_SIDE = 64,
  localparam int unsigned AW = $clog2(GRID_SIDE) + 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 wr_en_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic [GRID_SIDE-1:0] wdata_i,
  input  wire logic                 rd_en_i,
  input  wire logic [AW-1:0]        raddr_i,
  output logic      [GRID_SIDE-1:0] rdata_o
);

  localparam int unsigned DEPTH = 2 ** AW;

  logic [GRID_SIDE-1:0] row_mem [DEPTH];
  logic [GRID_SIDE-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      row_mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= row_mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/lla_window.sv]
// Three-row neighborhood window with rule lookup and next-row builder.
// Depends on lla_pkg for win_ctl_t and mask widths.
`default_nettype none

module lla_window #(
  parameter int unsigned GRID_SIDE = 64
) (
  input  wire logic                      clk_i,
  input  wire lla_pkg::win_ctl_t         ctl_i,
  input  wire logic [GRID_SIDE-1:0]      rd_data_i,
  input  wire logic [lla_pkg::MASK_W-1:0] birth_mask_i,
  input  wire logic [lla_pkg::MASK_W-1:0] survive_mask_i,
  output logic                           next_bit_o,
  output logic      [GRID_SIDE-1:0]      row_word_o
);

  import lla_pkg::*;

  localparam int unsigned TOP = GRID_SIDE - 1;

  // Bit 0 of each row register is the column being evaluated
  logic [GRID_SIDE-1:0] up_q, mid_q, dn_q, pre_q, out_q;
  logic [NCNT_W-1:0]    ncount;
  logic [MASK_W-1:0]    rule;

  function automatic logic [GRID_SIDE-1:0] rot(input logic [GRID_SIDE-1:0] x);
    rot = {x[0], x[TOP:1]};
  endfunction

  always_comb begin
    ncount = NCNT_W'(up_q[TOP]) + NCNT_W'(up_q[0]) + NCNT_W'(up_q[1])
           + NCNT_W'(mid_q[TOP]) + NCNT_W'(mid_q[1])
           + NCNT_W'(dn_q[TOP]) + NCNT_W'(dn_q[0]) + NCNT_W'(dn_q[1]);
    rule = mid_q[0] ? survive_mask_i : birth_mask_i;
    next_bit_o = rule[ncount];
    row_word_o = {next_bit_o, out_q[TOP:1]};
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.prime_shift) begin
      up_q  <= mid_q;
      mid_q <= dn_q;
      dn_q  <= rd_data_i;
    end else if (ctl_i.row_end) begin
      // last rotation restores alignment; bring in the prefetched row
      up_q  <= rot(mid_q);
      mid_q <= rot(dn_q);
      dn_q  <= pre_q;
    end else if (ctl_i.cell_adv) begin
      up_q  <= rot(up_q);
      mid_q <= rot(mid_q);
      dn_q  <= rot(dn_q);
    end
    if (ctl_i.cell_adv) begin
      out_q <= row_word_o;
    end
    if (ctl_i.pre_load) begin
      pre_q <= rd_data_i;
    end
  end

endmodule

`default_nettype wire

[sv/life_like_automaton_grid.sv]
// Top level of the life-like automaton grid: sequencer, counters, APB registers.
// Depends on lla_pkg, lla_row_mem and lla_window.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o  operation_i, col_i, row_i
//   out      source     out_valid_o / out_stall_i cell_on_o, live_count_o, generation_count_o
//   cfg      APB slave  psel, penable, pready    paddr, pwdata, prdata
//
// Toggle and read pass through memory read, modify/write and result states per word.
// Step primes the window, then evaluates one cell per cycle through the
// three-row window, one row read and one row write per grid row on the memory.
// After reset a clearing pass writes GRID_SIDE zero rows; input stalls meanwhile.
// A new word is taken while the previous result waits on out_stall_i.
`default_nettype none

module life_like_automaton_grid #(
  parameter int unsigned GRID_SIDE = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [lla_pkg::OP_W-1:0]       operation_i,
  input  wire logic [lla_pkg::COORD_W-1:0]    col_i,
  input  wire logic [lla_pkg::COORD_W-1:0]    row_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                cell_on_o,
  output logic      [lla_pkg::LIVE_OUT_W-1:0] live_count_o,
  output logic      [lla_pkg::GEN_W-1:0]      generation_count_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [lla_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [lla_pkg::PDATA_W-1:0]    pwdata,
  output logic      [lla_pkg::PDATA_W-1:0]    prdata,
  output logic                                pready
);

  import lla_pkg::*;

  localparam int unsigned CW = $clog2(GRID_SIDE);
  localparam int unsigned AW = CW + 1;
  localparam int unsigned LW = $clog2(GRID_SIDE * GRID_SIDE + 1);
  localparam logic [CW-1:0] LAST = CW'(GRID_SIDE - 1);

  state_e state_q, state_d;
  logic [CW-1:0] row_q, row_d, col_q, col_d;
  logic [CW-1:0] col_sel_q, col_sel_d, row_sel_q, row_sel_d;
  logic [1:0]    pc_q, pc_d;
  logic          bank_q, bank_d;
  logic [LW-1:0] cnt_q, cnt_d, live_q, live_d;
  logic [GEN_W-1:0] gen_q, gen_d;
  logic [OP_W-1:0]  op_q, op_d;
  logic          res_bit_q, res_bit_d;
  logic          rd_vld_q;
  logic [MASK_W-1:0] birth_q, survive_q;
  logic          out_valid_q;
  logic          cell_on_q;
  logic [LIVE_OUT_W-1:0] live_out_q;
  logic [GEN_W-1:0]      gen_out_q;
  logic          out_load;

  logic                 mem_wr_en, mem_rd_en;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [GRID_SIDE-1:0] mem_wdata, mem_rdata, flip_word, row_word;
  logic                 cell_bit, next_bit;
  logic [CW:0]          r2_sum;
  logic [CW-1:0]        r2;
  win_ctl_t             win_ctl;

  // Coordinate wrap as a constant table
  logic [CW-1:0] coord_tab [COORD_SPAN];
  for (genvar g = 0; g < COORD_SPAN; g++) begin : g_coord
    assign coord_tab[g] = CW'(g % GRID_SIDE);
  end

  lla_row_mem #(.GRID_SIDE(GRID_SIDE)) u_mem (
    .clk_i   (clk_i),
    .wr_en_i (mem_wr_en),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rd_en_i (mem_rd_en),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lla_window #(.GRID_SIDE(GRID_SIDE)) u_win (
    .clk_i          (clk_i),
    .ctl_i          (win_ctl),
    .rd_data_i      (mem_rdata),
    .birth_mask_i   (birth_q),
    .survive_mask_i (survive_q),
    .next_bit_o     (next_bit),
    .row_word_o     (row_word)
  );

  always_comb begin
    cell_bit  = mem_rdata[col_sel_q];
    flip_word = mem_rdata;
    flip_word[col_sel_q] = ~cell_bit;
    r2_sum = {1'b0, row_q} + (CW+1)'(2);
    r2 = (r2_sum >= (CW+1)'(GRID_SIDE)) ? CW'(r2_sum - (CW+1)'(GRID_SIDE))
                                        : r2_sum[CW-1:0];
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    pc_d      = pc_q;
    bank_d    = bank_q;
    cnt_d     = cnt_q;
    live_d    = live_q;
    gen_d     = gen_q;
    op_d      = op_q;
    col_sel_d = col_sel_q;
    row_sel_d = row_sel_q;
    res_bit_d = res_bit_q;
    mem_wr_en = 1'b0;
    mem_waddr = {bank_q, row_q};
    mem_wdata = '0;
    mem_rd_en = 1'b0;
    mem_raddr = {bank_q, row_sel_q};
    win_ctl   = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_wr_en = 1'b1;
        if (row_q == LAST) begin
          row_d   = '0;
          state_d = ST_IDLE;
        end else begin
          row_d = row_q + CW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d      = operation_i;
          col_sel_d = coord_tab[col_i];
          row_sel_d = coord_tab[row_i];
          if (operation_i == OP_STEP) begin
            pc_d    = '0;
            cnt_d   = '0;
            row_d   = '0;
            col_d   = '0;
            state_d = ST_PRIME;
          end else begin
            state_d = ST_CELL_RD;
          end
        end
      end
      ST_CELL_RD: begin
        mem_rd_en = 1'b1;
        state_d   = ST_CELL_MOD;
      end
      ST_CELL_MOD: begin
        res_bit_d = cell_bit;
        if (op_q == OP_TOGGLE) begin
          mem_wr_en = 1'b1;
          mem_waddr = {bank_q, row_sel_q};
          mem_wdata = flip_word;
          res_bit_d = ~cell_bit;
          live_d    = cell_bit ? live_q - LW'(1) : live_q + LW'(1);
        end
        state_d = ST_DONE;
      end
      ST_PRIME: begin
        // fetch rows last, 0 and 1 so the window starts centered on row 0
        win_ctl.prime_shift = rd_vld_q;
        pc_d = pc_q + 2'd1;
        unique case (pc_q)
          2'd0: begin
            mem_rd_en = 1'b1;
            mem_raddr = {bank_q, LAST};
          end
          2'd1: begin
            mem_rd_en = 1'b1;
            mem_raddr = {bank_q, CW'(0)};
          end
          2'd2: begin
            mem_rd_en = 1'b1;
            mem_raddr = {bank_q, CW'(1)};
          end
          default: begin
            state_d = ST_SWEEP;
          end
        endcase
      end
      ST_SWEEP: begin
        win_ctl.pre_load = rd_vld_q;
        cnt_d = cnt_q + LW'(next_bit);
        if (col_q == '0) begin
          mem_rd_en = 1'b1;
          mem_raddr = {bank_q, r2};
        end
        if (col_q == LAST) begin
          win_ctl.row_end = 1'b1;
          mem_wr_en = 1'b1;
          mem_waddr = {~bank_q, row_q};
          mem_wdata = row_word;
          col_d     = '0;
          if (row_q == LAST) begin
            row_d     = '0;
            live_d    = cnt_d;
            gen_d     = gen_q + GEN_W'(1);
            bank_d    = ~bank_q;
            res_bit_d = 1'b0;
            state_d   = ST_DONE;
          end else begin
            row_d = row_q + CW'(1);
          end
        end else begin
          win_ctl.cell_adv = 1'b1;
          col_d = col_q + CW'(1);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      row_q       <= '0;
      col_q       <= '0;
      pc_q        <= '0;
      bank_q      <= 1'b0;
      cnt_q       <= '0;
      live_q      <= '0;
      gen_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      row_q    <= row_d;
      col_q    <= col_d;
      pc_q     <= pc_d;
      bank_q   <= bank_d;
      cnt_q    <= cnt_d;
      live_q   <= live_d;
      gen_q    <= gen_d;
      rd_vld_q <= mem_rd_en;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    col_sel_q <= col_sel_d;
    row_sel_q <= row_sel_d;
    res_bit_q <= res_bit_d;
    if (out_load) begin
      cell_on_q  <= res_bit_q;
      live_out_q <= LIVE_OUT_W'(live_q);
      gen_out_q  <= gen_q;
    end
  end

  // Rule registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      birth_q   <= BIRTH_RESET;
      survive_q <= SURVIVE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[REG_SEL])
        REG_BIRTH:   birth_q   <= pwdata[MASK_W-1:0];
        REG_SURVIVE: survive_q <= pwdata[MASK_W-1:0];
        default:     birth_q   <= birth_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[REG_SEL])
      REG_BIRTH:   prdata = PDATA_W'(birth_q);
      REG_SURVIVE: prdata = PDATA_W'(survive_q);
      default:     prdata = '0;
    endcase
  end

  assign pready             = 1'b1;
  assign in_stall_o         = (state_q != ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign cell_on_o          = cell_on_q;
  assign live_count_o       = live_out_q;
  assign generation_count_o = gen_out_q;

endmodule

`default_nettype wire

[verif/life_like_automaton_grid_test.sv]
// Testbench for life_like_automaton_grid: directed probes, then random bursts
// checked against a cycle-free grid predictor. Depends on lla_pkg and the RTL.
`timescale 1ns / 1ps

module life_like_automaton_grid_test;
  import lla_pkg::*;

  localparam logic [OP_W-1:0]    OP_SPARE       = 2'd3;  // unused code, acts as a read
  localparam logic [PADDR_W-1:0] ADDR_BIRTH     = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_SURVIVE   = 3'd4;
  localparam int                 HOLD_CYCLES    = 300;
  localparam int                 WATCHDOG_LIMIT = 20000;
  localparam int                 REPORT_MAX     = 10;

  typedef struct packed {
    logic                  cell_on;
    logic [LIVE_OUT_W-1:0] live_count;
    logic [GEN_W-1:0]      generation;
  } report_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               pinned;
    report_t            rep;
  } probe_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [OP_W-1:0]       operation_i;
  logic [COORD_W-1:0]    col_i;
  logic [COORD_W-1:0]    row_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  cell_on_o;
  logic [LIVE_OUT_W-1:0] live_count_o;
  logic [GEN_W-1:0]      generation_count_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [PDATA_W-1:0]    pwdata;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  // Predictor state
  bit                grid [COORD_SPAN][COORD_SPAN];  // [row][col]
  int unsigned       live_cells = 0;
  logic [GEN_W-1:0]  generations = '0;
  logic [MASK_W-1:0] birth_rule = BIRTH_RESET;
  logic [MASK_W-1:0] survive_rule = SURVIVE_RESET;

  report_t pending_reports[$];
  probe_t  probe_tab[$];
  int      fault_count = 0;
  int      words_sent = 0;
  int      gap_pct = 0;
  int      stall_pct = 0;
  bit      hold_req = 1'b0;
  int      quiet_cycles = 0;

  life_like_automaton_grid DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .col_i              (col_i),
    .row_i              (row_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .cell_on_o          (cell_on_o),
    .live_count_o       (live_count_o),
    .generation_count_o (generation_count_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Apply one word to the grid and return what the block should report
  function automatic report_t grid_apply(input logic [OP_W-1:0] op,
                                         input logic [COORD_W-1:0] c,
                                         input logic [COORD_W-1:0] r);
    report_t           rep;
    bit                nxt [COORD_SPAN][COORD_SPAN];
    int unsigned       n;
    int unsigned       alive;
    int                side;
    logic [MASK_W-1:0] rule;
    side = COORD_SPAN;
    rep.cell_on = 1'b0;
    if (op == OP_STEP) begin
      alive = 0;
      for (int y = 0; y < side; y++) begin
        for (int x = 0; x < side; x++) begin
          n = 0;
          for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
              if (dx != 0 || dy != 0)
                n += grid[(y + dy + side) % side][(x + dx + side) % side];
          rule = grid[y][x] ? survive_rule : birth_rule;
          nxt[y][x] = rule[n];
          alive += rule[n];
        end
      end
      grid = nxt;
      live_cells = alive;
      generations = generations + 1'b1;
    end else begin
      if (op == OP_TOGGLE) begin
        grid[r][c] = !grid[r][c];
        if (grid[r][c]) live_cells++;
        else live_cells--;
      end
      rep.cell_on = grid[r][c];
    end
    rep.live_count = live_cells[LIVE_OUT_W-1:0];
    rep.generation = generations;
    return rep;
  endfunction

  task automatic probe_row(input logic [OP_W-1:0] op, input int c, input int r,
                           input bit pin = 1'b0, input bit on = 1'b0,
                           input int live = 0, input int gen = 0);
    probe_t p;
    p.op = op;
    p.col = COORD_W'(c);
    p.row = COORD_W'(r);
    p.pinned = pin;
    p.rep.cell_on = on;
    p.rep.live_count = LIVE_OUT_W'(live);
    p.rep.generation = GEN_W'(gen);
    probe_tab.insert(probe_tab.size(), p);
  endtask

  task automatic send_word(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] c,
                           input logic [COORD_W-1:0] r, input bit pin = 1'b0,
                           input report_t pinned_rep = '0);
    report_t rep;
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    operation_i = op;
    col_i = c;
    row_i = r;
    do @(posedge clk_i); while (in_stall_o);
    rep = grid_apply(op, c, r);
    pending_reports.insert(pending_reports.size(), pin ? pinned_rep : rep);
    words_sent++;
  endtask

  // Drop valid and hold until every outstanding result has come back
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_rule(input logic [PADDR_W-1:0] addr, input logic [MASK_W-1:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = {$urandom} & ~32'h1FF | PDATA_W'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (addr == ADDR_BIRTH) birth_rule = value;
    else survive_rule = value;
  endtask

  // Mostly small clustered patterns followed by steps and reads; some noise
  task automatic run_phase(input int quota);
    int                 stop_at;
    int                 pick;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic [OP_W-1:0]    op;
    stop_at = words_sent + quota;
    while (words_sent < stop_at) begin
      if ($urandom_range(99) < 70) begin
        bx = COORD_W'($urandom);
        by = COORD_W'($urandom);
        repeat ($urandom_range(3, 7))
          send_word(OP_TOGGLE, bx + COORD_W'($urandom_range(0, 4)),
                    by + COORD_W'($urandom_range(0, 4)));
        repeat ($urandom_range(1, 2))
          send_word(OP_STEP, COORD_W'($urandom), COORD_W'($urandom));
        repeat (2)
          send_word(OP_READ, bx + COORD_W'($urandom_range(0, 5)),
                    by + COORD_W'($urandom_range(0, 5)));
      end else begin
        pick = $urandom_range(0, 9);
        op = (pick < 4) ? OP_TOGGLE : (pick < 7) ? OP_READ : (pick < 9) ? OP_SPARE : OP_STEP;
        send_word(op, COORD_W'($urandom), COORD_W'($urandom));
      end
    end
    settle();
  endtask

  task automatic flag_fault(input string what, input report_t want, input report_t got);
    fault_count++;
    if (fault_count <= REPORT_MAX)
      $display("%0t: %s: expected on=%0d live=%0d gen=%0d, got on=%0d live=%0d gen=%0d",
               $realtime, what, want.cell_on, want.live_count, want.generation,
               got.cell_on, got.live_count, got.generation);
  endtask

  // Receiver: random stall, with a long hold-off when requested
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_stall_i = ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    report_t got;
    report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{cell_on_o, live_count_o, generation_count_o};
      if (pending_reports.size() == 0) begin
        flag_fault("result with nothing outstanding", '0, got);
      end else begin
        want = pending_reports.pop_front();
        if (got.cell_on !== want.cell_on || got.live_count !== want.live_count ||
            got.generation !== want.generation)
          flag_fault("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("life_like_automaton_grid test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = OP_READ;
    col_i = '0;
    row_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    // Pinned rows: empty grid, corner toggles, spare code, lone cell dying
    probe_row(OP_READ,    0,  0, 1, 0, 0, 0);
    probe_row(OP_TOGGLE, 63, 63, 1, 1, 1, 0);
    probe_row(OP_TOGGLE,  0,  0, 1, 1, 2, 0);
    probe_row(OP_SPARE,  63, 63, 1, 1, 2, 0);
    probe_row(OP_TOGGLE, 63, 63, 1, 0, 1, 0);
    probe_row(OP_TOGGLE,  0,  0, 1, 0, 0, 0);
    probe_row(OP_TOGGLE, 42, 21, 1, 1, 1, 0);
    probe_row(OP_STEP,   21, 42, 1, 0, 0, 1);
    probe_row(OP_READ,   42, 21, 1, 0, 0, 1);
    // Blinker straddling both grid edges
    probe_row(OP_TOGGLE, 63, 0);
    probe_row(OP_TOGGLE,  0, 0);
    probe_row(OP_TOGGLE,  1, 0);
    probe_row(OP_STEP,    0, 0);
    probe_row(OP_READ,    0, 63);
    probe_row(OP_STEP,   63, 63);
    probe_row(OP_READ,   63, 0);
    // Glider
    probe_row(OP_TOGGLE, 21, 40);
    probe_row(OP_TOGGLE, 22, 41);
    probe_row(OP_TOGGLE, 20, 42);
    probe_row(OP_TOGGLE, 21, 42);
    probe_row(OP_TOGGLE, 22, 42);
    probe_row(OP_STEP,    5, 58);
    probe_row(OP_STEP,   58, 5);
    probe_row(OP_READ,   22, 42);
    probe_row(OP_SPARE,  21, 41);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (probe_tab[i])
      send_word(probe_tab[i].op, probe_tab[i].col, probe_tab[i].row,
                probe_tab[i].pinned, probe_tab[i].rep);
    settle();

    // Everything born, everything survives
    write_rule(ADDR_BIRTH, 9'h1FF);
    write_rule(ADDR_SURVIVE, 9'h1FF);
    gap_pct = 50;
    stall_pct = 0;
    run_phase(15);

    // Nothing born, nothing survives
    write_rule(ADDR_BIRTH, 9'h000);
    write_rule(ADDR_SURVIVE, 9'h000);
    gap_pct = 0;
    stall_pct = 50;
    run_phase(15);

    write_rule(ADDR_BIRTH, BIRTH_RESET);
    write_rule(ADDR_SURVIVE, SURVIVE_RESET);
    gap_pct = 11;
    stall_pct = 11;
    run_phase(20);

    // B36/S23; fill the block behind a long receiver hold-off
    write_rule(ADDR_BIRTH, 9'h048);
    gap_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    repeat (10)
      send_word(($urandom_range(1) != 0) ? OP_TOGGLE : OP_READ,
                COORD_W'($urandom), COORD_W'($urandom));
    settle();
    run_phase(15);

    write_rule(ADDR_BIRTH, MASK_W'($urandom_range(0, 511)));
    write_rule(ADDR_SURVIVE, MASK_W'($urandom_range(0, 511)));
    gap_pct = 0;
    stall_pct = 50;
    run_phase(10);

    write_rule(ADDR_BIRTH, 9'h004);
    write_rule(ADDR_SURVIVE, 9'h000);
    gap_pct = 11;
    stall_pct = 11;
    run_phase(10);

    repeat (16) @(posedge clk_i);
    if (fault_count == 0 && pending_reports.size() == 0) begin
      $display("life_like_automaton_grid test passed");
    end else begin
      $display("life_like_automaton_grid test failed");
    end
    $finish;
  end

endmodule
